>>> hw/rtl/ntue_pkg.sv
// Shared types and constants for the neighbour table block.
// Depends on nothing; the controller, datapath and top level import it.
package ntue_pkg;

  localparam logic OP_UPSERT = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic [1:0] ACT_MATCH = 2'd0;
  localparam logic [1:0] ACT_FREE  = 2'd1;
  localparam logic [1:0] ACT_EVICT = 2'd2;
  localparam logic [1:0] ACT_SWEEP = 2'd3;

  localparam logic [31:0] TTL_RESET = 32'd30000;

  typedef struct packed {
    logic        op;
    logic [63:0] peer_name;
    logic [7:0]  peer_state;
    logic [7:0]  peer_minutes_left;
    logic [15:0] peer_completed;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0] action;
    logic [2:0] slot_written;
    logic [3:0] expired_count;
    logic [3:0] used_count;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture the beat, clear accumulators
    logic scan_rd;  // read the entry at the scan pointer, advance
    logic commit;   // write the chosen entry, load the result
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;
  } dp_stat_t;

endpackage

>>> hw/rtl/ntue_chan_if.sv
// Valid/ready channel carrying one beat of payload type T.
// Depends on nothing; the payload type is given at instantiation.
interface ntue_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/ntue_ctl.sv
// Sequencing state machine for the neighbour table: accept, scan, drain, commit.
// Depends on ntue_pkg for the command and status structs.
module ntue_ctl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output ntue_pkg::ctl_cmd_t cmd,
  input  ntue_pkg::dp_stat_t stat
);
  import ntue_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_COMMIT = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   res_valid;
  logic   proceed;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = res_valid;
  // hold the commit while an earlier result is still waiting
  assign proceed   = !res_valid || out_ready;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.scan_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (proceed) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) res_valid <= 1'b1;
      else if (out_ready) res_valid <= 1'b0;
    end
  end

endmodule

>>> hw/rtl/ntue_dp.sv
// Datapath of the neighbour table: entry memory, valid bits, scan accumulators.
// Depends on ntue_pkg for payload types, codes and the command/status structs.
module ntue_dp #(
  parameter int TABLE_ENTRIES = 8,
  parameter int NAME_BYTES    = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  ntue_pkg::in_item_t  in_data,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_data,
  input  ntue_pkg::ctl_cmd_t  cmd,
  output ntue_pkg::dp_stat_t  stat,
  output ntue_pkg::out_item_t res
);
  import ntue_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int NB    = NAME_BYTES * 8;
  localparam int ROW_W = NB + 64;

  logic [31:0]              ttl;
  logic [TABLE_ENTRIES-1:0] valid;
  logic [CNT_W-1:0]         used;
  logic [CNT_W-1:0]         used_next;

  // captured beat
  logic        op;
  logic [NB-1:0] key;
  logic [7:0]  status;
  logic [7:0]  minutes;
  logic [15:0] done_cnt;
  logic [31:0] now;

  // entry memory
  logic [ROW_W-1:0] mem [TABLE_ENTRIES];
  logic [ROW_W-1:0] rd_row;
  logic [ROW_W-1:0] wr_row;
  logic             mem_we;
  logic [IDX_W-1:0] cnt;

  // scan accumulators
  logic             eval_en;
  logic [IDX_W-1:0] eval_idx;
  logic             match_hit, free_hit;
  logic [IDX_W-1:0] match_idx, free_idx, min_idx;
  logic [31:0]      min_seen;
  logic [CNT_W-1:0] expired;

  logic [NB-1:0]    rd_name;
  logic [31:0]      rd_seen;
  logic [31:0]      age;
  logic             ev_valid;
  logic [IDX_W-1:0] slot;
  logic [1:0]       act;

  assign rd_name = rd_row[ROW_W-1 -: NB];
  assign rd_seen = rd_row[31:0];
  assign age     = now - rd_seen;
  assign ev_valid = valid[eval_idx];
  assign stat.scan_last = (cnt == IDX_W'(TABLE_ENTRIES - 1));

  assign wr_row = {key, status, minutes, done_cnt, now};
  assign mem_we = cmd.commit && (op == OP_UPSERT);

  always_comb begin
    if (op == OP_TICK) begin
      act  = ACT_SWEEP;
      slot = '0;
    end else if (match_hit) begin
      act  = ACT_MATCH;
      slot = match_idx;
    end else if (free_hit) begin
      act  = ACT_FREE;
      slot = free_idx;
    end else begin
      act  = ACT_EVICT;
      slot = min_idx;
    end
    used_next = (act == ACT_FREE) ? CNT_W'(used + 1'b1) : used;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[slot] <= wr_row;
    rd_row <= mem[cnt];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ttl     <= TTL_RESET;
      valid   <= '0;
      used    <= '0;
      eval_en <= 1'b0;
    end else begin
      if (cfg_we) ttl <= cfg_data;
      eval_en <= cmd.scan_rd;
      if (eval_en && op == OP_TICK && ev_valid && age > ttl) begin
        valid[eval_idx] <= 1'b0;
        used            <= CNT_W'(used - 1'b1);
      end else if (mem_we) begin
        valid[slot] <= 1'b1;
        used        <= used_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op        <= in_data.op;
      key       <= in_data.peer_name[NB-1:0];
      status    <= in_data.peer_state;
      minutes   <= in_data.peer_minutes_left;
      done_cnt  <= in_data.peer_completed;
      now       <= in_data.now_ms;
      cnt       <= '0;
      match_hit <= 1'b0;
      free_hit  <= 1'b0;
      expired   <= '0;
    end
    if (cmd.scan_rd) begin
      cnt      <= IDX_W'(cnt + 1'b1);
      eval_idx <= cnt;
    end
    if (eval_en) begin
      if (op == OP_TICK) begin
        if (ev_valid && age > ttl) expired <= CNT_W'(expired + 1'b1);
      end else begin
        if (ev_valid && rd_name == key && !match_hit) begin
          match_hit <= 1'b1;
          match_idx <= eval_idx;
        end
        if (!ev_valid && !free_hit) begin
          free_hit <= 1'b1;
          free_idx <= eval_idx;
        end
        // plain unsigned compare, lowest index keeps a tie
        if (eval_idx == '0 || rd_seen < min_seen) begin
          min_idx  <= eval_idx;
          min_seen <= rd_seen;
        end
      end
    end
    if (cmd.commit) begin
      res.action        <= act;
      res.slot_written  <= 3'(slot);
      res.expired_count <= 4'(expired);
      res.used_count    <= 4'(used_next);
    end
  end

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CNT_W'(TABLE_ENTRIES))
    else $error("used count beyond table size");

  a_scan_only_clears: assert property (@(posedge clk) disable iff (rst)
    eval_en |=> ((valid & ~$past(valid)) == '0))
    else $error("valid bit set during scan");

  a_upsert_grows_one: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> (used == $past(used)) || (used == CNT_W'($past(used) + 1'b1)))
    else $error("upsert changed used count by more than one");
`endif

endmodule

>>> hw/rtl/neighbor_table_upsert_expire_top.sv
// Top level of the neighbour table: joins controller, datapath and the channels.
// Depends on ntue_pkg, ntue_chan_if, ntue_ctl and ntue_dp.
//
// A table of TABLE_ENTRIES neighbour entries keyed by a NAME_BYTES-byte name.
// Op 0 (beacon) rewrites the valid entry with a matching name, else fills the
// lowest free entry, else evicts the entry with the smallest last-seen time
// (plain unsigned compare, lowest index on a tie); the entry takes the payload
// and now_ms. Op 1 (tick) frees every valid entry whose wrapping age
// now_ms - last_seen exceeds time_to_live_ms. Every beat in gives exactly one
// result beat out. Each item passes through a capture step, one memory read per
// entry as the scan walks the single-read-port entry memory, a drain of the
// registered read and a commit. The result sits in an output register, so the
// next beat is taken while it waits; a commit holds only if the previous result
// has still not been taken. Reset clears all valid bits at once; entry contents
// are read by the scan but used only once they have been written.
// time_to_live_ms resets to 30000 and is written through cfg_we/cfg_data; the
// user must write it only while the block is idle, which the block itself does
// not enforce.
module neighbor_table_upsert_expire_top #(
  parameter int TABLE_ENTRIES = 8,
  parameter int NAME_BYTES    = 8
) (
  input  logic        clk,
  input  logic        rst,
  ntue_chan_if.sink   in_ch,
  ntue_chan_if.source out_ch,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data
);
  import ntue_pkg::*;

  ctl_cmd_t  cmd;
  dp_stat_t  stat;
  out_item_t res;

  // sequencing: accept a beat, scan every entry, commit, present the result
  ntue_ctl u_ctl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // storage and per-entry evaluation
  ntue_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .NAME_BYTES    (NAME_BYTES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_ch.data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat),
    .res      (res)
  );

  // result register drives the outgoing beat
  assign out_ch.data = res;

endmodule
